FILE: sv/occupancy_cell_hit_counter_assert.svh
// Assertion macros for the occupancy cell hit counter.
// Included by the top level; uses the clk and rst names of the including module.
`ifndef OCCUPANCY_CELL_HIT_COUNTER_ASSERT_SVH
`define OCCUPANCY_CELL_HIT_COUNTER_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define OCHC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("occupancy cell hit counter: same-cycle check failed");

// The consequence must hold in the cycle after the antecedent.
`define OCHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("occupancy cell hit counter: next-cycle check failed");

`endif

FILE: sv/ochc_pkg.sv
// Shared types, codes and defaults of the occupancy cell hit counter.
// No dependencies; imported by the top level, the controller and the datapath.
package ochc_pkg;

  // Default geometry of the map.
  localparam int MAP_MM_DEF  = 4096;
  localparam int CELL_MM_DEF = 64;

  // Width of an offset coordinate after moving the origin to the map corner.
  localparam int Q_W    = 16;
  localparam int PROD_W = 2 * Q_W + 1;

  // Commands.
  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [1:0] CMD_DECAY    = 2'd2;
  localparam logic [1:0] CMD_PENDING  = 2'd3;

  // Cell status codes.
  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_FULL_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_HIT_CEILING    = 2'd1;
  localparam logic [1:0] CFG_DECAY_STEP     = 2'd2;
  localparam logic [7:0] FULL_THRESHOLD_RST = 8'd3;
  localparam logic [7:0] HIT_CEILING_RST    = 8'd255;
  localparam logic [7:0] DECAY_STEP_RST     = 8'd1;

  // One stored cell.
  typedef struct packed {
    logic       touched;
    logic [7:0] hits;
    logic [1:0] status;
  } ochc_word_t;

  localparam int WORD_W = $bits(ochc_word_t);

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_en;
    logic load;
    logic div_en;
    logic addr_en;
    logic rmw_en;
  } ochc_ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
  } ochc_stat_t;

endpackage

FILE: sv/occupancy_cell_hit_counter.sv
// Top level of the occupancy cell hit counter: controller plus datapath.
// Depends on ochc_pkg, ochc_ctrl, ochc_dp and the assertion macro header.
//
// Each item goes through these steps in order: accept, point-to-cell scaling
// (one reciprocal multiply), address formation with the cell memory read, and
// the write-back of the modified cell into the single-port-write memory, which
// also loads the result word. Items are handled one at a time; a new item is
// accepted while the previous result still waits in the output register, and
// it only holds at its write-back step if that result has not been taken.
// After reset a clearing pass writes each of the GRID_N * GRID_N cells once
// (4096 with the default map), during which no item is accepted;
// configuration writes are taken at any time.
`include "occupancy_cell_hit_counter_assert.svh"
module occupancy_cell_hit_counter import ochc_pkg::*; #(
  parameter int MAP_MM  = MAP_MM_DEF,
  parameter int CELL_MM = CELL_MM_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic [5:0]         cell_row,
  input  logic [5:0]         cell_col,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               cell_touched,
  output logic [7:0]         cell_hits,
  output logic [1:0]         cell_status,
  output logic               cell_full,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  ochc_ctl_t  ctl;
  ochc_stat_t stat;

  // Registers may be written in any cycle.
  assign cfg_ready = 1'b1;

  ochc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  ochc_dp #(
    .MAP_MM  (MAP_MM),
    .CELL_MM (CELL_MM)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .point_x      (point_x),
    .point_y      (point_y),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .cell_touched (cell_touched),
    .cell_hits    (cell_hits),
    .cell_status  (cell_status),
    .cell_full    (cell_full)
  );

  // One item in flight: an accepted word closes the input for the next cycle.
  `OCHC_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)
  // No item enters while the clearing pass still owns the memory.
  `OCHC_ASSERT_SAME(a_no_accept_in_clear, ctl.clear_en, in_stall && !ctl.load)
  // A write-back always presents its result in the following cycle.
  `OCHC_ASSERT_NEXT(a_result_shown, ctl.rmw_en, out_valid)

endmodule

FILE: sv/ochc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ochc_ram #(
  parameter int              WIDTH = 11,
  parameter longint unsigned DEPTH = 4096,
  localparam int             AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/ochc_ctrl.sv
// Sequencer of the occupancy cell hit counter: clearing pass, item steps, result slot.
// Depends on ochc_pkg.
module ochc_ctrl import ochc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  ochc_stat_t stat,
  output ochc_ctl_t  ctl
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_ADDR  = 3'd3;
  localparam logic [2:0] S_RMW   = 3'd4;

  logic [2:0] state, state_next;
  logic       slot_free;

  // The result slot can take a new word when empty or when its word leaves now.
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // Commands to the datapath.
  always_comb begin
    ctl          = '0;
    ctl.clear_en = (state == S_CLEAR);
    ctl.load     = (state == S_IDLE) && in_valid;
    ctl.div_en   = (state == S_DIV);
    ctl.addr_en  = (state == S_ADDR);
    ctl.rmw_en   = (state == S_RMW) && slot_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DIV;
      end
      S_DIV:   state_next = S_ADDR;
      S_ADDR:  state_next = S_RMW;
      S_RMW: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // State and result slot registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      priority if (ctl.rmw_en) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/ochc_dp.sv
// Datapath of the occupancy cell hit counter: registers, cell index math, cell memory.
// Depends on ochc_pkg and ochc_ram.
module ochc_dp import ochc_pkg::*; #(
  parameter int MAP_MM  = MAP_MM_DEF,
  parameter int CELL_MM = CELL_MM_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ochc_ctl_t          ctl,
  output ochc_stat_t         stat,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic [5:0]         cell_row,
  input  logic [5:0]         cell_col,
  output logic               cell_touched,
  output logic [7:0]         cell_hits,
  output logic [1:0]         cell_status,
  output logic               cell_full
);

  localparam int GRID_N = ((MAP_MM / CELL_MM) > 0) ? (MAP_MM / CELL_MM) : 1;
  localparam longint unsigned CELLS = longint'(GRID_N) * longint'(GRID_N);
  localparam int IDX_W  = (GRID_N > 1) ? $clog2(GRID_N) : 1;
  localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DIV_SH = Q_W + ((CELL_MM > 1) ? $clog2(CELL_MM) : 0);
  // Rounded-up reciprocal: exact floor division by CELL_MM for Q_W-bit dividends.
  localparam longint unsigned RECIP = ((64'd1 << DIV_SH) + CELL_MM - 1) / CELL_MM;

  // Configuration registers.
  logic [7:0] full_threshold, hit_ceiling, decay_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_threshold <= FULL_THRESHOLD_RST;
      hit_ceiling    <= HIT_CEILING_RST;
      decay_step     <= DECAY_STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FULL_THRESHOLD: full_threshold <= cfg_data;
        CFG_HIT_CEILING:    hit_ceiling    <= cfg_data;
        CFG_DECAY_STEP:     decay_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing pass counter over every cell after reset.
  logic [AW-1:0] clear_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (ctl.clear_en) begin
      clear_cnt <= clear_cnt + AW'(1);
    end
  end

  assign stat.clear_last = (clear_cnt == AW'(CELLS - 1));

  // Input word registers.
  logic [1:0]         cmd_q;
  logic signed [15:0] point_x_q, point_y_q;
  logic [5:0]         cell_row_q, cell_col_q;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q      <= cmd;
      point_x_q  <= point_x;
      point_y_q  <= point_y;
      cell_row_q <= cell_row;
      cell_col_q <= cell_col;
    end
  end

  // Move the origin to the map corner and scale by the reciprocal of the cell size.
  logic signed [Q_W+1:0] vx, vy;
  logic [Q_W-1:0]        ux, uy;
  logic [PROD_W-1:0]     prod_x, prod_y;
  logic                  low_x, low_y;

  assign vx = (Q_W+2)'(point_x_q) + (Q_W+2)'(MAP_MM / 2);
  assign vy = (Q_W+2)'(point_y_q) + (Q_W+2)'(MAP_MM / 2);
  assign ux = Q_W'(vx - (Q_W+2)'(1));
  assign uy = Q_W'(vy - (Q_W+2)'(1));

  always_ff @(posedge clk) begin
    if (ctl.div_en) begin
      prod_x <= PROD_W'(ux) * PROD_W'(RECIP);
      prod_y <= PROD_W'(uy) * PROD_W'(RECIP);
      low_x  <= (vx <= 0);
      low_y  <= (vy <= 0);
    end
  end

  // Clamp indexes to the grid and form the cell address.
  logic [Q_W-1:0]   qx, qy;
  logic [IDX_W-1:0] px_idx, py_idx, cr_idx, cc_idx, row_idx, col_idx;
  logic [AW-1:0]    addr_comb, addr_q;

  assign qx = Q_W'(prod_x >> DIV_SH);
  assign qy = Q_W'(prod_y >> DIV_SH);

  always_comb begin
    // Points on or below the lower map edge go to the first cell.
    if (low_x) px_idx = '0;
    else if (32'(qx) > GRID_N - 1) px_idx = IDX_W'(GRID_N - 1);
    else px_idx = IDX_W'(qx);
    if (low_y) py_idx = '0;
    else if (32'(qy) > GRID_N - 1) py_idx = IDX_W'(GRID_N - 1);
    else py_idx = IDX_W'(qy);
    // Cell indexes beyond the grid saturate to the last row or column.
    if (32'(cell_row_q) > GRID_N - 1) cr_idx = IDX_W'(GRID_N - 1);
    else cr_idx = IDX_W'(cell_row_q);
    if (32'(cell_col_q) > GRID_N - 1) cc_idx = IDX_W'(GRID_N - 1);
    else cc_idx = IDX_W'(cell_col_q);
    if (cmd_q == CMD_INSERT) begin
      row_idx = px_idx;
      col_idx = py_idx;
    end else begin
      row_idx = cr_idx;
      col_idx = cc_idx;
    end
    addr_comb = AW'(64'(row_idx) * 64'(GRID_N) + 64'(col_idx));
  end

  always_ff @(posedge clk) begin
    if (ctl.addr_en) begin
      addr_q <= addr_comb;
    end
  end

  // Cell memory.
  logic              we;
  logic [AW-1:0]     waddr;
  ochc_word_t        wword, rword;
  logic [WORD_W-1:0] rdata;

  ochc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (WORD_W'(wword)),
    .re    (ctl.addr_en),
    .raddr (addr_comb),
    .rdata (rdata)
  );

  assign rword = ochc_word_t'(rdata);

  // Read-modify-write of the addressed cell.
  ochc_word_t nword;
  logic [7:0] h_base;
  logic [8:0] h_inc;

  always_comb begin
    nword  = rword;
    h_base = rword.touched ? rword.hits : 8'd0;
    h_inc  = {1'b0, h_base} + 9'd1;
    unique case (cmd_q)
      CMD_INSERT: begin
        nword.touched = 1'b1;
        nword.status  = ST_PENDING;
        nword.hits    = (h_inc > {1'b0, hit_ceiling}) ? hit_ceiling : h_inc[7:0];
      end
      CMD_CLASSIFY: begin
        nword.status = (rword.hits >= full_threshold) ? ST_FULL : ST_EMPTY;
      end
      CMD_DECAY: begin
        if (rword.status != ST_EMPTY && rword.hits > decay_step) begin
          nword.hits = rword.hits - decay_step;
        end else begin
          nword.hits = 8'd0;
        end
      end
      CMD_PENDING: begin
        nword.status = ST_PENDING;
      end
    endcase
  end

  // The clearing pass owns the write port until it ends.
  assign we    = ctl.clear_en || ctl.rmw_en;
  assign waddr = ctl.clear_en ? clear_cnt : addr_q;
  assign wword = ctl.clear_en ? '0 : nword;

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.rmw_en) begin
      cell_touched <= nword.touched;
      cell_hits    <= nword.hits;
      cell_status  <= nword.status;
      cell_full    <= (nword.status == ST_FULL);
    end
  end

endmodule
